### hw/rtl/pvfm_pkg.sv
// Shared types, constants and register codes of the pack voltage fault monitor.
`default_nettype none
package pvfm_pkg;

    localparam int PVFM_PACK_COUNT = 6;

    localparam int VOLT_W  = 16;
    localparam int PSUM_W  = 20;
    localparam int SUM_W   = 24;
    localparam int CNT_W   = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [VOLT_W-1:0] MIN_RELOAD = 16'd50000;
    localparam logic [SUM_W-1:0]  SUM_SAT    = 24'hFFFFFF;

    localparam logic [VOLT_W-1:0] RST_UV_SET  = 16'd28000;
    localparam logic [VOLT_W-1:0] RST_UV_CLR  = 16'd30000;
    localparam logic [VOLT_W-1:0] RST_OV_SET  = 16'd36000;
    localparam logic [VOLT_W-1:0] RST_OV_CLR  = 16'd34000;
    localparam logic [CNT_W-1:0]  RST_LIMIT   = 4'd5;
    localparam logic [VOLT_W-1:0] RST_AUX_LVL = 16'd13500;

    localparam logic [CFG_IDX_W-1:0] CFG_UV_SET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UV_CLR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OV_SET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OV_CLR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AUX_LVL = 3'd5;

    typedef struct packed {
        logic [VOLT_W-1:0] uv_set;
        logic [VOLT_W-1:0] uv_clr;
        logic [VOLT_W-1:0] ov_set;
        logic [VOLT_W-1:0] ov_clr;
        logic [CNT_W-1:0]  limit;
        logic [VOLT_W-1:0] aux_lvl;
    } t_cfg;

    typedef struct packed {
        logic [VOLT_W-1:0] cell_min;
        logic [VOLT_W-1:0] cell_max;
        logic [SUM_W-1:0]  sum;
        logic [VOLT_W-1:0] aux;
    } t_scan;

    typedef struct packed {
        logic [VOLT_W-1:0] cell_min;
        logic [VOLT_W-1:0] cell_max;
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  quot_est;
        logic              uv_error;
        logic              ov_error;
        logic              aux_low;
        logic [CNT_W-1:0]  uv_count;
        logic [CNT_W-1:0]  ov_count;
    } t_eval;

endpackage
`default_nettype wire

### hw/rtl/pvfm_cfg.sv
// Configuration register file with reset defaults.
`default_nettype none
module pvfm_cfg
    import pvfm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire logic [CFG_IDX_W-1:0] i_index,
    input  wire logic [VOLT_W-1:0]    i_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.uv_set  <= RST_UV_SET;
            r_cfg.uv_clr  <= RST_UV_CLR;
            r_cfg.ov_set  <= RST_OV_SET;
            r_cfg.ov_clr  <= RST_OV_CLR;
            r_cfg.limit   <= RST_LIMIT;
            r_cfg.aux_lvl <= RST_AUX_LVL;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_UV_SET:  r_cfg.uv_set  <= i_data;
                CFG_UV_CLR:  r_cfg.uv_clr  <= i_data;
                CFG_OV_SET:  r_cfg.ov_set  <= i_data;
                CFG_OV_CLR:  r_cfg.ov_clr  <= i_data;
                CFG_LIMIT:   r_cfg.limit   <= i_data[CNT_W-1:0];
                CFG_AUX_LVL: r_cfg.aux_lvl <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### hw/rtl/pvfm_scan.sv
// Running minimum, maximum and saturating sum over a scan, and the scan register.
`default_nettype none
module pvfm_scan
    import pvfm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_load,
    input  wire logic [VOLT_W-1:0] i_pack_cell_min,
    input  wire logic [VOLT_W-1:0] i_pack_cell_max,
    input  wire logic [PSUM_W-1:0] i_pack_sum,
    input  wire logic [VOLT_W-1:0] i_aux_voltage,
    input  wire logic              i_last_pack,
    output logic                   o_valid,
    output t_scan                  o_scan
);

    logic [VOLT_W-1:0] r_run_min, n_run_min;
    logic [VOLT_W-1:0] r_run_max, n_run_max;
    logic [SUM_W-1:0]  r_run_sum, n_run_sum;
    logic [SUM_W:0]    sum_wide;
    logic              r_valid;
    t_scan             r_scan;

    always_comb begin
        n_run_min = (i_pack_cell_min < r_run_min) ? i_pack_cell_min : r_run_min;
        n_run_max = (i_pack_cell_max > r_run_max) ? i_pack_cell_max : r_run_max;
        sum_wide  = {1'b0, r_run_sum} + (SUM_W+1)'(i_pack_sum);
        n_run_sum = sum_wide[SUM_W] ? SUM_SAT : sum_wide[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_min <= MIN_RELOAD;
            r_run_max <= '0;
            r_run_sum <= '0;
        end else if (i_accept) begin
            if (i_last_pack) begin
                r_run_min <= MIN_RELOAD;
                r_run_max <= '0;
                r_run_sum <= '0;
            end else begin
                r_run_min <= n_run_min;
                r_run_max <= n_run_max;
                r_run_sum <= n_run_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_accept && i_last_pack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_accept && i_last_pack) begin
            r_scan.cell_min <= n_run_min;
            r_scan.cell_max <= n_run_max;
            r_scan.sum      <= n_run_sum;
            r_scan.aux      <= i_aux_voltage;
        end
    end

    assign o_valid = r_valid;
    assign o_scan  = r_scan;

endmodule
`default_nettype wire

### hw/rtl/pvfm_eval.sv
// Hysteresis flags, debounce counters, error latches and the quotient estimate.
`default_nettype none
module pvfm_eval
    import pvfm_pkg::*;
#(
    parameter int PACK_COUNT = PVFM_PACK_COUNT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic  i_load,
    input  wire t_cfg  i_cfg,
    input  wire t_scan i_scan,
    output logic       o_valid,
    output t_eval      o_eval
);

    localparam int DIV = PACK_COUNT / 2;
    localparam logic [SUM_W:0] RECIP = (SUM_W+1)'((2 ** SUM_W) / DIV);

    function automatic logic [CNT_W-1:0] f_count(
        input logic [CNT_W-1:0] cnt,
        input logic             up,
        input logic [CNT_W-1:0] lim
    );
        logic [CNT_W:0] c;
        c = {1'b0, cnt};
        if (up) begin
            c = c + (CNT_W+1)'(1);
        end else if (c != '0) begin
            c = c - (CNT_W+1)'(1);
        end
        if (c > {1'b0, lim}) begin
            c = {1'b0, lim};
        end
        return c[CNT_W-1:0];
    endfunction

    function automatic logic f_latch(
        input logic             latched,
        input logic [CNT_W-1:0] cnt,
        input logic [CNT_W-1:0] lim
    );
        logic res;
        res = latched;
        if (cnt == lim) begin
            res = 1'b1;
        end else if (cnt == '0) begin
            res = 1'b0;
        end
        return res;
    endfunction

    logic                r_uv_raw, n_uv_raw;
    logic                r_ov_raw, n_ov_raw;
    logic [CNT_W-1:0]    r_uv_cnt, n_uv_cnt;
    logic [CNT_W-1:0]    r_ov_cnt, n_ov_cnt;
    logic                r_uv_lat, n_uv_lat;
    logic                r_ov_lat, n_ov_lat;
    logic                r_aux_lat, n_aux_lat;
    logic [CNT_W-1:0]    lim;
    logic [2*SUM_W:0]    prod;
    logic                r_valid;
    t_eval               r_eval;
    logic                step;

    assign step = i_valid && i_load;

    always_comb begin
        lim = (i_cfg.limit == '0) ? CNT_W'(1) : i_cfg.limit;

        if (i_scan.cell_min <= i_cfg.uv_set) begin
            n_uv_raw = 1'b1;
        end else if (i_scan.cell_min >= i_cfg.uv_clr) begin
            n_uv_raw = 1'b0;
        end else begin
            n_uv_raw = r_uv_raw;
        end

        if (i_scan.cell_max >= i_cfg.ov_set) begin
            n_ov_raw = 1'b1;
        end else if (i_scan.cell_max <= i_cfg.ov_clr) begin
            n_ov_raw = 1'b0;
        end else begin
            n_ov_raw = r_ov_raw;
        end

        n_uv_cnt  = f_count(r_uv_cnt, n_uv_raw, lim);
        n_ov_cnt  = f_count(r_ov_cnt, n_ov_raw, lim);
        n_uv_lat  = f_latch(r_uv_lat, n_uv_cnt, lim);
        n_ov_lat  = f_latch(r_ov_lat, n_ov_cnt, lim);
        n_aux_lat = r_aux_lat || (i_scan.aux < i_cfg.aux_lvl);

        prod = (2*SUM_W+1)'(i_scan.sum) * (2*SUM_W+1)'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv_raw  <= 1'b0;
            r_ov_raw  <= 1'b0;
            r_uv_cnt  <= '0;
            r_ov_cnt  <= '0;
            r_uv_lat  <= 1'b0;
            r_ov_lat  <= 1'b0;
            r_aux_lat <= 1'b0;
        end else if (step) begin
            r_uv_raw  <= n_uv_raw;
            r_ov_raw  <= n_ov_raw;
            r_uv_cnt  <= n_uv_cnt;
            r_ov_cnt  <= n_ov_cnt;
            r_uv_lat  <= n_uv_lat;
            r_ov_lat  <= n_ov_lat;
            r_aux_lat <= n_aux_lat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_eval.cell_min <= i_scan.cell_min;
            r_eval.cell_max <= i_scan.cell_max;
            r_eval.sum      <= i_scan.sum;
            r_eval.quot_est <= prod[2*SUM_W-1:SUM_W];
            r_eval.uv_error <= n_uv_lat;
            r_eval.ov_error <= n_ov_lat;
            r_eval.aux_low  <= n_aux_lat;
            r_eval.uv_count <= n_uv_cnt;
            r_eval.ov_count <= n_ov_cnt;
        end
    end

    assign o_valid = r_valid;
    assign o_eval  = r_eval;

endmodule
`default_nettype wire

### hw/rtl/pvfm_out.sv
// Quotient correction and the result register.
`default_nettype none
module pvfm_out
    import pvfm_pkg::*;
#(
    parameter int PACK_COUNT = PVFM_PACK_COUNT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_load,
    input  wire t_eval         i_eval,
    output logic               o_valid,
    output logic [VOLT_W-1:0]  o_cell_min,
    output logic [VOLT_W-1:0]  o_cell_max,
    output logic [SUM_W-1:0]   o_total_value,
    output logic               o_uv_error,
    output logic               o_ov_error,
    output logic               o_aux_low,
    output logic               o_relay_enable,
    output logic [CNT_W-1:0]   o_uv_count,
    output logic [CNT_W-1:0]   o_ov_count
);

    localparam int DIV = PACK_COUNT / 2;
    localparam logic [SUM_W+2:0] DIV_W = (SUM_W+3)'(DIV);

    logic [SUM_W+2:0] back;
    logic [SUM_W+2:0] rem;
    logic [SUM_W-1:0] quot;
    logic             r_valid;
    t_eval            r_res;
    t_eval            n_res;

    // The estimate is at most one below the true quotient.
    always_comb begin
        back = (SUM_W+3)'(i_eval.quot_est) * DIV_W;
        rem  = (SUM_W+3)'(i_eval.sum) - back;
        quot = i_eval.quot_est + SUM_W'(rem >= DIV_W);
        n_res = i_eval;
        n_res.quot_est = quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid        = r_valid;
    assign o_cell_min     = r_res.cell_min;
    assign o_cell_max     = r_res.cell_max;
    assign o_total_value  = r_res.quot_est;
    assign o_uv_error     = r_res.uv_error;
    assign o_ov_error     = r_res.ov_error;
    assign o_aux_low      = r_res.aux_low;
    assign o_relay_enable = !(r_res.uv_error || r_res.ov_error);
    assign o_uv_count     = r_res.uv_count;
    assign o_ov_count     = r_res.ov_count;

endmodule
`default_nettype wire

### hw/rtl/pack_voltage_fault_monitor_core.sv
// Top level of the pack voltage fault monitor.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_valid / o_stall         pack_cell_min/max, pack_sum, aux, last
//   result    out        o_valid / i_stall         scan min/max, total, error bits, counts
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One pack item is accepted per cycle while o_stall is low; the scan accumulators
// fold it on acceptance. A last-pack item shows its result through the scan,
// evaluation and result registers; the divide is a reciprocal multiply plus one fix-up.
// Each stage moves when the stage after it is empty or moving, so bubbles close up.
// Reset is synchronous and clears all control state and the monitor flags.
`default_nettype none
module pack_voltage_fault_monitor_core
    import pvfm_pkg::*;
#(
    parameter int PACK_COUNT = PVFM_PACK_COUNT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [VOLT_W-1:0]    i_pack_cell_min,
    input  wire logic [VOLT_W-1:0]    i_pack_cell_max,
    input  wire logic [PSUM_W-1:0]    i_pack_sum,
    input  wire logic [VOLT_W-1:0]    i_aux_voltage,
    input  wire logic                 i_last_pack,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [VOLT_W-1:0]         o_cell_min,
    output logic [VOLT_W-1:0]         o_cell_max,
    output logic [SUM_W-1:0]          o_total_value,
    output logic                      o_uv_error,
    output logic                      o_ov_error,
    output logic                      o_aux_low,
    output logic                      o_relay_enable,
    output logic [CNT_W-1:0]          o_uv_count,
    output logic [CNT_W-1:0]          o_ov_count,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [VOLT_W-1:0]    i_cfg_data
);

    t_cfg  cfg;
    t_scan scan;
    t_eval eval_q;
    logic  scan_valid;
    logic  eval_valid;
    logic  rdy_scan;
    logic  rdy_eval;
    logic  rdy_out;
    logic  accept;

    assign rdy_out     = !o_valid || !i_stall;
    assign rdy_eval    = !eval_valid || rdy_out;
    assign rdy_scan    = !scan_valid || rdy_eval;
    assign o_stall     = !rdy_scan;
    assign accept      = i_valid && rdy_scan;
    assign o_cfg_ready = 1'b1;

    pvfm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    pvfm_scan u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_load          (rdy_scan),
        .i_pack_cell_min (i_pack_cell_min),
        .i_pack_cell_max (i_pack_cell_max),
        .i_pack_sum      (i_pack_sum),
        .i_aux_voltage   (i_aux_voltage),
        .i_last_pack     (i_last_pack),
        .o_valid         (scan_valid),
        .o_scan          (scan)
    );

    pvfm_eval #(
        .PACK_COUNT (PACK_COUNT)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (scan_valid),
        .i_load  (rdy_eval),
        .i_cfg   (cfg),
        .i_scan  (scan),
        .o_valid (eval_valid),
        .o_eval  (eval_q)
    );

    pvfm_out #(
        .PACK_COUNT (PACK_COUNT)
    ) u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (eval_valid),
        .i_load         (rdy_out),
        .i_eval         (eval_q),
        .o_valid        (o_valid),
        .o_cell_min     (o_cell_min),
        .o_cell_max     (o_cell_max),
        .o_total_value  (o_total_value),
        .o_uv_error     (o_uv_error),
        .o_ov_error     (o_ov_error),
        .o_aux_low      (o_aux_low),
        .o_relay_enable (o_relay_enable),
        .o_uv_count     (o_uv_count),
        .o_ov_count     (o_ov_count)
    );

endmodule
`default_nettype wire

### hw/rtl/pvfm_checker.sv
// Port-level checker for the pack voltage fault monitor and its bind.
`default_nettype none
module pvfm_checker
    import pvfm_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_valid,
    input wire logic                 o_stall,
    input wire logic [VOLT_W-1:0]    i_pack_cell_min,
    input wire logic [VOLT_W-1:0]    i_pack_cell_max,
    input wire logic [PSUM_W-1:0]    i_pack_sum,
    input wire logic [VOLT_W-1:0]    i_aux_voltage,
    input wire logic                 i_last_pack,
    input wire logic                 o_valid,
    input wire logic                 i_stall,
    input wire logic [VOLT_W-1:0]    o_cell_min,
    input wire logic [VOLT_W-1:0]    o_cell_max,
    input wire logic [SUM_W-1:0]     o_total_value,
    input wire logic                 o_uv_error,
    input wire logic                 o_ov_error,
    input wire logic                 o_aux_low,
    input wire logic                 o_relay_enable,
    input wire logic [CNT_W-1:0]     o_uv_count,
    input wire logic [CNT_W-1:0]     o_ov_count,
    input wire logic                 i_cfg_valid,
    input wire logic                 o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [VOLT_W-1:0]    i_cfg_data
);

    logic r_aux_seen;

    // The auxiliary flag is sticky, so once reported it stays set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aux_seen <= 1'b0;
        end else if (o_valid && !i_stall && o_aux_low) begin
            r_aux_seen <= 1'b1;
        end
    end

    a_aux_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_aux_seen |-> o_aux_low)
        else $error("aux low flag cleared after being reported");

    a_error_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_uv_error || o_uv_count != '0) && (!o_ov_error || o_ov_count != '0))
        else $error("error bit set with a zero debounce count");

    a_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cell_min <= MIN_RELOAD && o_total_value <= SUM_SAT)
        else $error("scan minimum above its reload value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cell_min) && $stable(o_uv_count))
        else $error("stalled result changed");

endmodule

bind pack_voltage_fault_monitor_core pvfm_checker u_pvfm_checker (.*);
`default_nettype wire

### test/tb.sv
// Self-checking testbench for the pack voltage fault monitor against a predictor.
`timescale 1ns / 1ps
module tb;
    import pvfm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_DIRECTED = 21;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_READINGS = 118;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [VOLT_W-1:0] cell_min;
        logic [VOLT_W-1:0] cell_max;
        logic [PSUM_W-1:0] sum;
        logic [VOLT_W-1:0] aux;
        logic              last_pack;
    } t_pack_reading;

    typedef struct packed {
        logic [VOLT_W-1:0] cell_min;
        logic [VOLT_W-1:0] cell_max;
        logic [SUM_W-1:0]  total;
        logic              uv_error;
        logic              ov_error;
        logic              aux_low;
        logic              relay_enable;
        logic [CNT_W-1:0]  uv_count;
        logic [CNT_W-1:0]  ov_count;
    } t_scan_report;

    typedef struct packed {
        t_pack_reading reading;
        logic          typed;
        t_scan_report  report;
    } t_directed_row;

    localparam t_scan_report NO_REPORT = '0;

    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{32000, 33000, 300, 20000, 1}, 1,
          '{32000, 33000, 100, 0, 0, 0, 1, 0, 0}},
        '{'{65535, 0, 0, 65535, 1}, 1,
          '{50000, 0, 0, 0, 0, 0, 1, 0, 0}},
        '{'{0, 65535, 20'hFFFFF, 0, 0}, 0, NO_REPORT},
        '{'{31000, 35000, 0, 65535, 1}, 1,
          '{0, 65535, 349525, 0, 0, 0, 1, 1, 1}},
        '{'{0, 65535, 0, 65535, 1}, 0, NO_REPORT},
        '{'{0, 65535, 0, 65535, 1}, 0, NO_REPORT},
        '{'{0, 65535, 0, 65535, 1}, 0, NO_REPORT},
        '{'{0, 65535, 0, 65535, 1}, 0, NO_REPORT},
        '{'{29000, 35000, 600, 65535, 1}, 0, NO_REPORT},
        '{'{30000, 34000, 0, 65535, 1}, 0, NO_REPORT},
        '{'{30000, 34000, 0, 65535, 1}, 0, NO_REPORT},
        '{'{30000, 34000, 0, 65535, 1}, 0, NO_REPORT},
        '{'{30000, 34000, 0, 65535, 1}, 0, NO_REPORT},
        '{'{30000, 34000, 0, 65535, 1}, 0, NO_REPORT},
        '{'{28000, 36000, 0, 65535, 1}, 0, NO_REPORT},
        '{'{40000, 20000, 0, 13500, 1}, 0, NO_REPORT},
        '{'{40000, 20000, 0, 13499, 1}, 1,
          '{40000, 20000, 0, 0, 0, 1, 1, 0, 0}},
        '{'{16'hAAAA, 16'h5555, 20'hAAAAA, 65535, 0}, 0, NO_REPORT},
        '{'{16'h5555, 16'hAAAA, 20'h55555, 65535, 0}, 0, NO_REPORT},
        '{'{45000, 40000, 12345, 16'h5555, 1}, 0, NO_REPORT},
        '{'{60000, 100, 1, 16'hAAAA, 1}, 0, NO_REPORT}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [VOLT_W-1:0]    i_pack_cell_min = '0;
    logic [VOLT_W-1:0]    i_pack_cell_max = '0;
    logic [PSUM_W-1:0]    i_pack_sum = '0;
    logic [VOLT_W-1:0]    i_aux_voltage = '0;
    logic                 i_last_pack = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [VOLT_W-1:0]    o_cell_min;
    logic [VOLT_W-1:0]    o_cell_max;
    logic [SUM_W-1:0]     o_total_value;
    logic                 o_uv_error;
    logic                 o_ov_error;
    logic                 o_aux_low;
    logic                 o_relay_enable;
    logic [CNT_W-1:0]     o_uv_count;
    logic [CNT_W-1:0]     o_ov_count;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [VOLT_W-1:0]    i_cfg_data = '0;

    pack_voltage_fault_monitor_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pack_cell_min(i_pack_cell_min),
        .i_pack_cell_max(i_pack_cell_max),
        .i_pack_sum     (i_pack_sum),
        .i_aux_voltage  (i_aux_voltage),
        .i_last_pack    (i_last_pack),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cell_min     (o_cell_min),
        .o_cell_max     (o_cell_max),
        .o_total_value  (o_total_value),
        .o_uv_error     (o_uv_error),
        .o_ov_error     (o_ov_error),
        .o_aux_low      (o_aux_low),
        .o_relay_enable (o_relay_enable),
        .o_uv_count     (o_uv_count),
        .o_ov_count     (o_ov_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_cfg              monitor_cfg = '{RST_UV_SET, RST_UV_CLR, RST_OV_SET, RST_OV_CLR,
                                       RST_LIMIT, RST_AUX_LVL};
    logic [VOLT_W-1:0] scan_min = MIN_RELOAD;
    logic [VOLT_W-1:0] scan_max = '0;
    logic [SUM_W-1:0]  scan_sum = '0;
    logic              uv_raw = 1'b0;
    logic              ov_raw = 1'b0;
    logic [CNT_W-1:0]  uv_debounce = '0;
    logic [CNT_W-1:0]  ov_debounce = '0;
    logic              uv_tripped = 1'b0;
    logic              ov_tripped = 1'b0;
    logic              aux_tripped = 1'b0;

    t_scan_report      pending_reports [$];
    logic              typed_on = 1'b0;
    t_scan_report      typed_report = '0;
    int                mismatches = 0;
    int                cycle_count = 0;
    int                readings_sent = 0;
    int                burst_left = 0;
    bit                steady_sender = 1'b0;
    int                stall_left = 0;

    function automatic logic [CNT_W-1:0] debounce_next(logic [CNT_W-1:0] count, logic up,
                                                       logic [CNT_W-1:0] limit);
        logic [CNT_W:0] next;
        next = {1'b0, count};
        if (up) begin
            next = next + 1'b1;
        end else if (next != 0) begin
            next = next - 1'b1;
        end
        if (next > limit) begin
            next = limit;
        end
        return next[CNT_W-1:0];
    endfunction

    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] index,
                                   input logic [VOLT_W-1:0] data);
        case (index)
            CFG_UV_SET:  monitor_cfg.uv_set = data;
            CFG_UV_CLR:  monitor_cfg.uv_clr = data;
            CFG_OV_SET:  monitor_cfg.ov_set = data;
            CFG_OV_CLR:  monitor_cfg.ov_clr = data;
            CFG_LIMIT:   monitor_cfg.limit = data[CNT_W-1:0];
            CFG_AUX_LVL: monitor_cfg.aux_lvl = data;
            default: ;
        endcase
    endtask

    task automatic fold_reading(input t_pack_reading rd, output logic done,
                                output t_scan_report rep);
        logic [SUM_W:0]   wide_sum;
        logic [CNT_W-1:0] limit;
        int unsigned      divisor;
        rep = '0;
        if (rd.cell_min < scan_min) begin
            scan_min = rd.cell_min;
        end
        if (rd.cell_max > scan_max) begin
            scan_max = rd.cell_max;
        end
        wide_sum = {1'b0, scan_sum} + rd.sum;
        scan_sum = (wide_sum > SUM_SAT) ? SUM_SAT : wide_sum[SUM_W-1:0];
        done = rd.last_pack;
        if (rd.last_pack) begin
            if (scan_min <= monitor_cfg.uv_set) begin
                uv_raw = 1'b1;
            end else if (scan_min >= monitor_cfg.uv_clr) begin
                uv_raw = 1'b0;
            end
            if (scan_max >= monitor_cfg.ov_set) begin
                ov_raw = 1'b1;
            end else if (scan_max <= monitor_cfg.ov_clr) begin
                ov_raw = 1'b0;
            end
            limit = (monitor_cfg.limit == 0) ? 4'd1 : monitor_cfg.limit;
            uv_debounce = debounce_next(uv_debounce, uv_raw, limit);
            ov_debounce = debounce_next(ov_debounce, ov_raw, limit);
            uv_tripped = (uv_debounce == limit) ? 1'b1 : (uv_debounce == 0) ? 1'b0 : uv_tripped;
            ov_tripped = (ov_debounce == limit) ? 1'b1 : (ov_debounce == 0) ? 1'b0 : ov_tripped;
            if (rd.aux < monitor_cfg.aux_lvl) begin
                aux_tripped = 1'b1;
            end
            divisor = PVFM_PACK_COUNT / 2;
            if (divisor == 0) begin
                divisor = 1;
            end
            rep.cell_min = scan_min;
            rep.cell_max = scan_max;
            rep.total = scan_sum / divisor;
            rep.uv_error = uv_tripped;
            rep.ov_error = ov_tripped;
            rep.aux_low = aux_tripped;
            rep.relay_enable = !(uv_tripped || ov_tripped);
            rep.uv_count = uv_debounce;
            rep.ov_count = ov_debounce;
            scan_min = MIN_RELOAD;
            scan_max = '0;
            scan_sum = '0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_pack_reading rd;
        t_scan_report  rep;
        t_scan_report  want;
        logic          done;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
            end
            if (i_valid && !o_stall) begin
                rd = '{i_pack_cell_min, i_pack_cell_max, i_pack_sum, i_aux_voltage, i_last_pack};
                fold_reading(rd, done, rep);
                if (done) begin
                    pending_reports.push_back(typed_on ? typed_report : rep);
                end
            end
            if (o_valid && !i_stall) begin
                if (pending_reports.size() == 0) begin
                    $error("Result item arrived with no expectation waiting.");
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("cell_min", want.cell_min, o_cell_min);
                    check_field("cell_max", want.cell_max, o_cell_max);
                    check_field("total_value", want.total, o_total_value);
                    check_field("uv_error", want.uv_error, o_uv_error);
                    check_field("ov_error", want.ov_error, o_ov_error);
                    check_field("aux_low", want.aux_low, o_aux_low);
                    check_field("relay_enable", want.relay_enable, o_relay_enable);
                    check_field("uv_count", want.uv_count, o_uv_count);
                    check_field("ov_count", want.ov_count, o_ov_count);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    i_stall = 1'b0;
                    stall_left = $urandom_range(20, 80);
                end
                1: begin
                    i_stall = 1'b1;
                    stall_left = $urandom_range(1, 8);
                end
                default: begin
                    i_stall = $urandom_range(0, 1);
                    stall_left = $urandom_range(0, 3);
                end
            endcase
        end
    end

    task automatic send_reading(input t_pack_reading rd);
        if (burst_left == 0) begin
            i_valid = 1'b0;
            if (!steady_sender) begin
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid = 1'b1;
        i_pack_cell_min = rd.cell_min;
        i_pack_cell_max = rd.cell_max;
        i_pack_sum = rd.sum;
        i_aux_voltage = rd.aux;
        i_last_pack = rd.last_pack;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        readings_sent++;
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [VOLT_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [VOLT_W-1:0] near_level(logic [VOLT_W-1:0] level);
        int v;
        v = int'(level) + int'($urandom_range(0, 3000)) - 1500;
        if (v < 0) begin
            v = 0;
        end else if (v > 65535) begin
            v = 65535;
        end
        return v[VOLT_W-1:0];
    endfunction

    task automatic program_phase(input int phase);
        logic [VOLT_W-1:0] uv_set, uv_clr, ov_set, ov_clr, limit_word, aux_lvl;
        uv_set = $urandom_range(20000, 34000);
        uv_clr = uv_set + $urandom_range(0, 4000);
        ov_set = $urandom_range(30000, 45000);
        ov_clr = ov_set - $urandom_range(0, 4000);
        limit_word = {12'($urandom_range(0, 4095)), 4'($urandom_range(1, 15))};
        aux_lvl = $urandom_range(0, 65535);
        case (phase)
            0: begin
                uv_set = 16'hFFFF;
                uv_clr = 16'hFFFF;
                ov_set = 16'h0000;
                ov_clr = 16'h0000;
                limit_word = 16'h000F;
                aux_lvl = 16'h0000;
            end
            1: begin
                uv_set = 16'hFFFF;
                uv_clr = 16'hFFFF;
                ov_set = 16'h0000;
                ov_clr = 16'h0000;
                limit_word = 16'h0002;
            end
            2: limit_word = 16'hFFF0;
            3: begin
                uv_set = 16'h0000;
                uv_clr = 16'h0000;
                ov_set = 16'hFFFF;
                ov_clr = 16'hFFFF;
                limit_word = 16'h0001;
                aux_lvl = 16'hFFFF;
            end
            4: begin
                uv_set = 31000;
                uv_clr = 29000;
                ov_set = 33000;
                ov_clr = 35000;
                limit_word = 16'h0003;
            end
            default: ;
        endcase
        steady_sender = (phase % 3 == 1);
        write_reg(CFG_UV_SET, uv_set);
        write_reg(CFG_UV_CLR, uv_clr);
        write_reg(CFG_OV_SET, ov_set);
        write_reg(CFG_OV_CLR, ov_clr);
        write_reg(CFG_LIMIT, limit_word);
        write_reg(CFG_AUX_LVL, aux_lvl);
        write_reg(phase[0] ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom_range(0, 65535));
    endtask

    task automatic send_scan();
        t_pack_reading rd;
        int            packs;
        bit            heavy;
        heavy = ($urandom_range(0, 19) == 0);
        packs = heavy ? $urandom_range(17, 20) : $urandom_range(1, 8);
        for (int k = 0; k < packs; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2:    rd.cell_min = near_level(monitor_cfg.uv_set);
                3, 4, 5:    rd.cell_min = near_level(monitor_cfg.uv_clr);
                6, 7:       rd.cell_min = $urandom_range(0, 65535);
                8:          rd.cell_min = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default:    rd.cell_min = $urandom_range(30000, 45000);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2:    rd.cell_max = near_level(monitor_cfg.ov_set);
                3, 4, 5:    rd.cell_max = near_level(monitor_cfg.ov_clr);
                6, 7:       rd.cell_max = $urandom_range(0, 65535);
                8:          rd.cell_max = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default:    rd.cell_max = $urandom_range(20000, 34000);
            endcase
            rd.sum = heavy ? 20'hFFFFF - $urandom_range(0, 255) : $urandom_range(0, 20'hFFFFF);
            rd.aux = $urandom_range(0, 65535);
            rd.last_pack = (k == packs - 1);
            send_reading(rd);
        end
    endtask

    initial begin
        int phase_start;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            typed_on = DIRECTED_ROWS[i].typed;
            typed_report = DIRECTED_ROWS[i].report;
            send_reading(DIRECTED_ROWS[i].reading);
        end
        typed_on = 1'b0;
        wait_drained();
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            program_phase(phase);
            phase_start = readings_sent;
            while (readings_sent - phase_start < PHASE_READINGS) begin
                send_scan();
            end
            wait_drained();
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
